// ===== rtl/core/stt_pkg.sv =====
// Shared types, constants and character classes for the source text tokenizer.
package stt_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 20;

  localparam int LEN_BITS    = 16;
  localparam int VALUE_BITS  = 31;
  localparam int OUT_LINE_W  = 16;
  localparam int OUT_COL_W   = 16;
  localparam int OUT_OFF_W   = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VALUE_BITS-1:0] INT_LIMIT = '1;
  localparam logic [LEN_BITS-1:0]   LEN_LIMIT = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [3:0] RADIX    = 4'd10;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_MINUS
  } mode_t;

  typedef enum logic [2:0] {
    KIND_EOF   = 3'd0,
    KIND_IDENT = 3'd1,
    KIND_INT   = 3'd2,
    KIND_MINUS = 3'd3,
    KIND_ARROW = 3'd4,
    KIND_CHAR  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             char_code;
    logic [OUT_LINE_W-1:0]  line;
    logic [OUT_COL_W-1:0]   column;
    logic [OUT_OFF_W-1:0]   offset;
    logic [LEN_BITS-1:0]    length;
    logic [VALUE_BITS-1:0]  value;
    logic                   overflow;
    logic                   last;
  } token_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return c inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z], CH_UNDER};
  endfunction

endpackage

// ===== rtl/core/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: scanner state, token build and output queue.
//
// One text byte is taken per cycle while in_stall is low. Each byte completes
// zero, one or two tokens, which go into a four-entry output queue whose head
// drives the result ports. The queue sends one token per cycle while out_stall is
// low, so bytes that each complete one token stream at one per cycle, while bytes
// that complete two tokens fill the queue until in_stall holds them back. in_stall
// is raised while the queue holds more than two tokens. End of text (or a zero byte)
// flushes the pending token, sends EOF and puts line, column and offset back to their start.
module source_text_tokenizer #(
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      text_byte,
  input  logic                            end_of_text,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      token_kind,
  output logic [7:0]                      char_code,
  output logic [stt_pkg::OUT_LINE_W-1:0]  token_line,
  output logic [stt_pkg::OUT_COL_W-1:0]   token_column,
  output logic [stt_pkg::OUT_OFF_W-1:0]   start_offset,
  output logic [stt_pkg::LEN_BITS-1:0]    token_length,
  output logic [stt_pkg::VALUE_BITS-1:0]  int_value,
  output logic                            value_overflow,
  output logic                            last_of_step
);
  import stt_pkg::*;

  localparam int LW = (LINE_BITS > OUT_LINE_W) ? LINE_BITS : OUT_LINE_W;
  localparam int CW = (COLUMN_BITS > OUT_COL_W) ? COLUMN_BITS : OUT_COL_W;
  localparam int OW = (OFFSET_BITS > OUT_OFF_W) ? OFFSET_BITS : OUT_OFF_W;
  localparam int PROD_BITS = VALUE_BITS + 4;

  mode_t                   mode, mode_next;
  logic [LINE_BITS-1:0]    cur_line, cur_line_next;
  logic [COLUMN_BITS-1:0]  cur_column, cur_column_next;
  logic [OFFSET_BITS-1:0]  cur_offset, cur_offset_next;
  logic [LINE_BITS-1:0]    start_line, start_line_next;
  logic [COLUMN_BITS-1:0]  start_column, start_column_next;
  logic [OFFSET_BITS-1:0]  start_position, start_position_next;
  logic [LEN_BITS-1:0]     span_length, span_length_next;
  logic [VALUE_BITS-1:0]   accumulated_value, accumulated_value_next;
  logic                    overflow_seen, overflow_seen_next;

  token_t                  queue [QUEUE_DEPTH];
  token_t                  queue_next [QUEUE_DEPTH];
  logic [CNT_BITS-1:0]     count, count_next;

  logic                    in_fire, pop;
  logic                    eof, ident_cont, int_cont, arrow_hit, other;
  logic                    ch_space, ch_digit, ch_word, ch_minus, ch_single;
  logic [3:0]              digit;
  logic [PROD_BITS-1:0]    prod;
  logic [VALUE_BITS-1:0]   acc_added;
  logic                    acc_ovf;
  logic [LINE_BITS-1:0]    adv_line;
  logic [COLUMN_BITS-1:0]  adv_column;
  logic [OFFSET_BITS-1:0]  adv_offset;
  logic [LEN_BITS-1:0]     span_inc;

  logic [LW-1:0]           cur_line_ext, start_line_ext;
  logic [CW-1:0]           cur_col_ext, start_col_ext;
  logic [OW-1:0]           cur_off_ext, start_off_ext;

  token_t                  tok_a, tok_b, push0, push1;
  logic                    tok_a_valid, tok_b_valid;
  logic [1:0]              push_n;
  logic [CNT_BITS-1:0]     cnt_after;

  // Handshake and classification
  assign in_stall  = (count > CNT_BITS'(QUEUE_DEPTH - 2));
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;

  assign eof        = end_of_text || (text_byte == CH_NUL);
  assign ch_space   = is_space(text_byte);
  assign ch_digit   = is_digit(text_byte);
  assign ch_word    = is_word_start(text_byte);
  assign ch_minus   = (text_byte == CH_MINUS);
  assign ch_single  = !ch_space && !ch_digit && !ch_word && !ch_minus;
  assign ident_cont = !eof && (mode == MODE_IDENT) && (ch_word || ch_digit);
  assign int_cont   = !eof && (mode == MODE_INT) && ch_digit;
  assign arrow_hit  = !eof && (mode == MODE_MINUS) && (text_byte == CH_GT);
  assign other      = !eof && !ident_cont && !int_cont && !arrow_hit;

  // Decimal accumulate with saturation: acc * 10 + digit
  assign digit     = 4'(text_byte - CH_ZERO);
  assign prod      = PROD_BITS'({accumulated_value, 3'b000})
                   + PROD_BITS'({accumulated_value, 1'b0})
                   + PROD_BITS'(digit);
  assign acc_ovf   = (prod > PROD_BITS'(INT_LIMIT));
  assign acc_added = acc_ovf ? INT_LIMIT : prod[VALUE_BITS-1:0];

  // Saturating position advance
  assign adv_offset = (cur_offset == '1) ? cur_offset : cur_offset + OFFSET_BITS'(1);
  assign adv_line   = (text_byte != CH_LF) ? cur_line :
                      ((cur_line == '1) ? cur_line : cur_line + LINE_BITS'(1));
  assign adv_column = (text_byte == CH_LF) ? COLUMN_BITS'(1) :
                      ((cur_column == '1) ? cur_column : cur_column + COLUMN_BITS'(1));
  assign span_inc   = (span_length == LEN_LIMIT) ? span_length
                                                 : span_length + LEN_BITS'(1);

  assign cur_line_ext   = LW'(cur_line);
  assign start_line_ext = LW'(start_line);
  assign cur_col_ext    = CW'(cur_column);
  assign start_col_ext  = CW'(start_column);
  assign cur_off_ext    = OW'(cur_offset);
  assign start_off_ext  = OW'(start_position);

  // Tokens completed by this byte: A is the pending or arrow token, B is EOF or a single char
  always_comb begin
    tok_a        = '0;
    tok_a.line   = start_line_ext[OUT_LINE_W-1:0];
    tok_a.column = start_col_ext[OUT_COL_W-1:0];
    tok_a.offset = start_off_ext[OUT_OFF_W-1:0];
    tok_a_valid  = 1'b0;
    if (arrow_hit) begin
      tok_a.kind   = KIND_ARROW;
      tok_a.length = LEN_BITS'(2);
      tok_a_valid  = 1'b1;
    end else begin
      case (mode)
        MODE_IDENT: begin
          tok_a.kind   = KIND_IDENT;
          tok_a.length = span_length;
        end
        MODE_INT: begin
          tok_a.kind     = KIND_INT;
          tok_a.length   = span_length;
          tok_a.value    = accumulated_value;
          tok_a.overflow = overflow_seen;
        end
        MODE_MINUS: begin
          tok_a.kind   = KIND_MINUS;
          tok_a.length = LEN_BITS'(1);
        end
        default: begin
          tok_a.kind = KIND_EOF;
        end
      endcase
      tok_a_valid = (eof || other) && (mode != MODE_IDLE);
    end

    tok_b           = '0;
    tok_b.kind      = eof ? KIND_EOF : KIND_CHAR;
    tok_b.char_code = eof ? 8'h00 : text_byte;
    tok_b.line      = cur_line_ext[OUT_LINE_W-1:0];
    tok_b.column    = cur_col_ext[OUT_COL_W-1:0];
    tok_b.offset    = cur_off_ext[OUT_OFF_W-1:0];
    tok_b.length    = LEN_BITS'(1);
    tok_b.last      = 1'b1;
    tok_b_valid     = eof || (other && ch_single);
    tok_a.last      = !tok_b_valid;
  end

  // Scanner next state
  always_comb begin
    mode_next              = mode;
    cur_line_next          = cur_line;
    cur_column_next        = cur_column;
    cur_offset_next        = cur_offset;
    start_line_next        = start_line;
    start_column_next      = start_column;
    start_position_next    = start_position;
    span_length_next       = span_length;
    accumulated_value_next = accumulated_value;
    overflow_seen_next     = overflow_seen;
    if (in_fire) begin
      if (eof) begin
        mode_next              = MODE_IDLE;
        cur_line_next          = LINE_BITS'(1);
        cur_column_next        = COLUMN_BITS'(1);
        cur_offset_next        = '0;
        start_line_next        = LINE_BITS'(1);
        start_column_next      = COLUMN_BITS'(1);
        start_position_next    = '0;
        span_length_next       = '0;
        accumulated_value_next = '0;
        overflow_seen_next     = 1'b0;
      end else begin
        cur_line_next   = adv_line;
        cur_column_next = adv_column;
        cur_offset_next = adv_offset;
        if (ident_cont) begin
          span_length_next = span_inc;
        end else if (int_cont) begin
          span_length_next       = span_inc;
          accumulated_value_next = acc_added;
          overflow_seen_next     = overflow_seen || acc_ovf;
        end else if (arrow_hit) begin
          mode_next = MODE_IDLE;
        end else begin
          mode_next = MODE_IDLE;
          if (!ch_space) begin
            start_line_next        = cur_line;
            start_column_next      = cur_column;
            start_position_next    = cur_offset;
            span_length_next       = '0;
            accumulated_value_next = '0;
            overflow_seen_next     = 1'b0;
            if (ch_word) begin
              mode_next        = MODE_IDENT;
              span_length_next = LEN_BITS'(1);
            end else if (ch_digit) begin
              mode_next              = MODE_INT;
              span_length_next       = LEN_BITS'(1);
              accumulated_value_next = VALUE_BITS'(digit);
            end else if (ch_minus) begin
              mode_next        = MODE_MINUS;
              span_length_next = LEN_BITS'(1);
            end
          end
        end
      end
    end
  end

  // Output queue: entry 0 is the head
  assign push0     = tok_a_valid ? tok_a : tok_b;
  assign push1     = tok_b;
  assign push_n    = in_fire ? (2'(tok_a_valid) + 2'(tok_b_valid)) : 2'd0;
  assign cnt_after = count - CNT_BITS'(pop);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i < QUEUE_DEPTH - 1)) begin
        queue_next[i] = queue[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end else begin
        queue_next[i] = queue[i];
      end
      if ((push_n != 2'd0) && (cnt_after == CNT_BITS'(i))) begin
        queue_next[i] = push0;
      end
      if ((push_n == 2'd2) && (cnt_after + CNT_BITS'(1) == CNT_BITS'(i))) begin
        queue_next[i] = push1;
      end
    end
    count_next = cnt_after + CNT_BITS'(push_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_IDLE;
      cur_line          <= LINE_BITS'(1);
      cur_column        <= COLUMN_BITS'(1);
      cur_offset        <= '0;
      start_line        <= LINE_BITS'(1);
      start_column      <= COLUMN_BITS'(1);
      start_position    <= '0;
      span_length       <= '0;
      accumulated_value <= '0;
      overflow_seen     <= 1'b0;
      count             <= '0;
    end else begin
      mode              <= mode_next;
      cur_line          <= cur_line_next;
      cur_column        <= cur_column_next;
      cur_offset        <= cur_offset_next;
      start_line        <= start_line_next;
      start_column      <= start_column_next;
      start_position    <= start_position_next;
      span_length       <= span_length_next;
      accumulated_value <= accumulated_value_next;
      overflow_seen     <= overflow_seen_next;
      count             <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

  assign token_kind     = queue[0].kind;
  assign char_code      = queue[0].char_code;
  assign token_line     = queue[0].line;
  assign token_column   = queue[0].column;
  assign start_offset   = queue[0].offset;
  assign token_length   = queue[0].length;
  assign int_value      = queue[0].value;
  assign value_overflow = queue[0].overflow;
  assign last_of_step   = queue[0].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("output queue overfilled");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && eof |=> (mode == MODE_IDLE) && (cur_offset == '0)
                       && (cur_line == LINE_BITS'(1)) && (cur_column == COLUMN_BITS'(1)))
    else $error("position not restarted after end of text");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    in_fire && (push_n != 2'd0) |=> out_valid)
    else $error("token request lost");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (queue[0].kind == KIND_EOF) |-> last_of_step)
    else $error("EOF token not marked last of step");

endmodule
